>>> design/mroe_pkg.sv
// Shared types and codes for the matrix row operation engine.
// Depends on nothing; every design file imports it.
package mroe_pkg;

    // Default array size.
    localparam int DEF_MAX_ROWS = 16;
    localparam int DEF_MAX_COLS = 16;

    // Operation codes.
    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_SWAP  = 3'd2;
    localparam logic [2:0] OP_MUL   = 3'd3;
    localparam logic [2:0] OP_DIV   = 3'd4;
    localparam logic [2:0] OP_ADD   = 3'd5;

    // Status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_DIVZ  = 2'd2;
    localparam logic [1:0] STAT_SAT   = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_COL_COUNT = 1'b1;

    // Divider: quotient bits, one per cycle.
    localparam int DIV_BITS  = 48;
    localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);

    typedef struct packed {
        logic [2:0]         op;
        logic [3:0]         row_a;
        logic [3:0]         row_b;
        logic [3:0]         col;
        logic signed [31:0] value;
    } mroe_req_t;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic [1:0]         status;
    } mroe_rsp_t;

    // Divider status toward the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } mroe_div_stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_SWAP2,
        S_MULT,
        S_DIV
    } mroe_state_t;

endpackage

>>> design/mroe_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mroe_pkg.
module mroe_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mroe_pkg::DIV_BITS-1:0] dividend,
    input  logic [31:0]                  divisor,
    output logic [mroe_pkg::DIV_BITS-1:0] quotient,
    output mroe_pkg::mroe_div_stat_t     stat
);
    import mroe_pkg::*;

    logic [32:0]          rem_reg;
    logic [32:0]          rem_next;
    logic [DIV_BITS-1:0]  dvd_reg;
    logic [DIV_BITS-1:0]  dvd_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 active_reg;
    logic                 done_reg;
    logic [32:0]          rem_shift;
    logic                 qbit;

    // Shift in one dividend bit and try the subtract
    always_comb
    begin
        rem_shift = {rem_reg[31:0], dvd_reg[DIV_BITS-1]};
        qbit      = (rem_shift >= {1'b0, divisor});
        rem_next  = qbit ? (rem_shift - {1'b0, divisor}) : rem_shift;
        dvd_next  = {dvd_reg[DIV_BITS-2:0], qbit};
    end

    // Control: count down the quotient bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= DIV_CNT_W'(DIV_BITS);
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
        end
        else if (active_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    assign quotient  = dvd_reg;
    assign stat.busy = active_reg;
    assign stat.done = done_reg;

endmodule

>>> design/matrix_row_operation_engine.sv
// Matrix row operation engine top level: request sequencer, element memory,
// multiply, divide and saturate datapath. Depends on mroe_pkg and mroe_div.
//
// Channel   Ports                              Transfer
// request   start, busy, request               start & !busy
// result    done, result                       done (one cycle, no stall)
// config    cfg_wr_en, cfg_index, cfg_data     cfg_wr_en
//
// Element reads pass S_READ and S_LOAD; writes and errors finish from idle.
// Each swap column passes S_READ, S_LOAD and S_SWAP2, multiply and add pass
// S_READ, S_LOAD and S_MULT, divide waits in S_DIV on the 48-step serial
// divider. The memory has one write port, so each column is read, worked
// and written back before the next one is read. Reset clears control only;
// matrix contents stay undefined until written. Results cannot be stalled.
module matrix_row_operation_engine #(
    parameter int MAX_ROWS = mroe_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = mroe_pkg::DEF_MAX_COLS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  mroe_pkg::mroe_req_t request,
    output logic                done,
    output mroe_pkg::mroe_rsp_t result,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [4:0]          cfg_data
);
    import mroe_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_COLS);
    localparam int CNW   = $clog2(MAX_COLS + 1);

    function automatic logic [AW-1:0] elem_addr(input logic [3:0] r, input logic [CW-1:0] c);
        elem_addr = AW'(AW'(r) * AW'(MAX_COLS) + AW'(c));
    endfunction

    // Saturate to 32 bits; top bit of result flags saturation
    function automatic logic [32:0] sat32(input logic signed [48:0] v);
        if (v > 49'sd2147483647)
            sat32 = {1'b1, 32'h7FFF_FFFF};
        else if (v < -49'sd2147483648)
            sat32 = {1'b1, 32'h8000_0000};
        else
            sat32 = {1'b0, v[31:0]};
    endfunction

    logic signed [31:0] mem [DEPTH];

    mroe_state_t        state_reg;
    mroe_state_t        state_next;
    mroe_req_t          req_reg;
    logic [CW-1:0]      col_idx_reg;
    logic signed [31:0] elem_reg;
    logic signed [63:0] prod_reg;
    logic               sat_reg;
    logic               done_reg;
    mroe_rsp_t          result_reg;
    logic [4:0]         row_count_reg;
    logic [4:0]         col_count_reg;
    logic signed [31:0] rd_a_reg;
    logic signed [31:0] rd_b_reg;

    logic               acc;
    logic               elem_op;
    logic               row_op;
    logic               ra_bad;
    logic               rb_bad;
    logic               col_bad;
    logic               bad;
    logic               divz;
    logic               go;
    logic [1:0]         chk_status;
    logic [CNW-1:0]     col_nxt;
    logic               col_last;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic signed [31:0] mem_wdata;
    logic [AW-1:0]      rd_addr_a;
    logic [AW-1:0]      rd_addr_b;
    logic [AW-1:0]      addr_a_col;
    logic [AW-1:0]      addr_b_col;

    logic               fin;
    logic [1:0]         fin_status;
    logic signed [31:0] fin_data;
    logic               col_step;
    logic               cur_sat;

    logic signed [63:0] rnd;
    logic signed [48:0] sh49;
    logic [32:0]        mul_res;
    logic [31:0]        e_mag;
    logic [31:0]        x_mag;
    logic               div_neg;
    logic [DIV_BITS-1:0] div_dividend;
    logic [DIV_BITS-1:0] div_q;
    logic signed [48:0] div_val;
    logic [32:0]        div_res;
    logic               div_start;
    mroe_div_stat_t     div_stat;

    // Check an incoming request
    always_comb
    begin
        acc     = start && (state_reg == S_IDLE);
        elem_op = (request.op == OP_WRITE) || (request.op == OP_READ);
        row_op  = (request.op == OP_SWAP) || (request.op == OP_MUL) ||
                  (request.op == OP_DIV) || (request.op == OP_ADD);
        ra_bad  = (32'(request.row_a) >= 32'(row_count_reg)) ||
                  (32'(request.row_a) >= 32'(MAX_ROWS));
        rb_bad  = (32'(request.row_b) >= 32'(row_count_reg)) ||
                  (32'(request.row_b) >= 32'(MAX_ROWS));
        col_bad = (32'(request.col) >= 32'(col_count_reg)) ||
                  (32'(request.col) >= 32'(MAX_COLS));
        if (elem_op)
            bad = ra_bad || col_bad;
        else if (row_op)
            bad = ra_bad || (((request.op == OP_SWAP) || (request.op == OP_ADD)) && rb_bad);
        else
            bad = 1'b0;
        divz = (request.op == OP_DIV) && (request.value == 32'sd0);
        go   = !bad && !divz &&
               ((request.op == OP_READ) || (row_op && (col_count_reg != 5'd0)));
        if (bad)
            chk_status = STAT_RANGE;
        else if (divz)
            chk_status = STAT_DIVZ;
        else
            chk_status = STAT_OK;
    end

    // Column walk end
    always_comb
    begin
        col_nxt  = CNW'(col_idx_reg) + CNW'(1);
        col_last = (32'(col_nxt) >= 32'(col_count_reg)) || (32'(col_nxt) == 32'(MAX_COLS));
    end

    // Arithmetic on the current column
    always_comb
    begin
        rnd     = prod_reg + 64'sd32768;
        sh49    = {rnd[63], rnd[63:16]};
        if (req_reg.op == OP_ADD)
            mul_res = sat32(sh49 + {{17{elem_reg[31]}}, elem_reg});
        else
            mul_res = sat32(sh49);
        e_mag   = rd_a_reg[31] ? (~rd_a_reg + 32'd1) : rd_a_reg;
        x_mag   = req_reg.value[31] ? (~req_reg.value + 32'd1) : req_reg.value;
        div_dividend = {e_mag, 16'd0} + DIV_BITS'(x_mag >> 1);
        div_neg = elem_reg[31] != req_reg.value[31];
        div_val = div_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
        div_res = sat32(div_val);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (acc && go)
                    state_next = S_READ;
            S_READ:
                state_next = S_LOAD;
            S_LOAD:
                case (req_reg.op)
                    OP_READ: state_next = S_IDLE;
                    OP_SWAP: state_next = S_SWAP2;
                    OP_DIV:  state_next = S_DIV;
                    default: state_next = S_MULT;
                endcase
            S_SWAP2, S_MULT:
                state_next = col_last ? S_IDLE : S_READ;
            S_DIV:
                if (div_stat.done)
                    state_next = col_last ? S_IDLE : S_READ;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: memory access, finish, column step
    always_comb
    begin
        addr_a_col = elem_addr(req_reg.row_a, col_idx_reg);
        addr_b_col = elem_addr(req_reg.row_b, col_idx_reg);
        rd_addr_a  = (req_reg.op == OP_READ) ? elem_addr(req_reg.row_a, CW'(req_reg.col))
                                             : addr_a_col;
        rd_addr_b  = addr_b_col;
        mem_we     = 1'b0;
        mem_waddr  = addr_a_col;
        mem_wdata  = rd_b_reg;
        fin        = 1'b0;
        fin_status = STAT_OK;
        fin_data   = 32'sd0;
        col_step   = 1'b0;
        cur_sat    = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (acc && !go)
                begin
                    fin        = 1'b1;
                    fin_status = chk_status;
                    if (request.op == OP_WRITE && !bad)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = elem_addr(request.row_a, CW'(request.col));
                        mem_wdata = request.value;
                    end
                end
            end
            S_LOAD:
            begin
                if (req_reg.op == OP_READ)
                begin
                    fin      = 1'b1;
                    fin_data = rd_a_reg;
                end
                else if (req_reg.op == OP_SWAP)
                begin
                    mem_we = 1'b1;
                end
                else if (req_reg.op == OP_DIV)
                begin
                    div_start = 1'b1;
                end
            end
            S_SWAP2:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_b_col;
                mem_wdata = elem_reg;
                col_step  = 1'b1;
            end
            S_MULT:
            begin
                mem_we    = 1'b1;
                mem_wdata = mul_res[31:0];
                cur_sat   = mul_res[32];
                col_step  = 1'b1;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = div_res[31:0];
                    cur_sat   = div_res[32];
                    col_step  = 1'b1;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
        if (col_step && col_last)
        begin
            fin        = 1'b1;
            fin_status = (sat_reg || cur_sat) ? STAT_SAT : STAT_OK;
        end
    end

    // Element memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            row_count_reg <= 5'd16;
            col_count_reg <= 5'd16;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= fin;
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_ROW_COUNT)
                    row_count_reg <= cfg_data;
                else
                    col_count_reg <= cfg_data;
            end
        end
    end

    // Hold the request, walk columns, latch operands and results
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            req_reg     <= request;
            col_idx_reg <= '0;
            sat_reg     <= 1'b0;
        end
        else if (col_step)
        begin
            col_idx_reg <= col_nxt[CW-1:0];
            sat_reg     <= sat_reg || cur_sat;
        end
        if (state_reg == S_LOAD)
        begin
            elem_reg <= rd_a_reg;
            if (req_reg.op == OP_ADD)
                prod_reg <= req_reg.value * rd_b_reg;
            else
                prod_reg <= rd_a_reg * req_reg.value;
        end
        if (fin)
        begin
            result_reg.read_data <= fin_data;
            result_reg.status    <= fin_status;
        end
    end

    mroe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (x_mag),
        .quotient (div_q),
        .stat     (div_stat)
    );

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // A result only appears once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");

    // An accepted request either finishes at once or occupies the engine
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("request dropped");

    // While waiting on the divider it is running or just finished
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_stat.busy || div_stat.done))
        else $error("divider idle during divide");

    // Memory is written from idle only for an element write request
    a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == S_IDLE) |-> (start && request.op == OP_WRITE))
        else $error("stray memory write");

endmodule

>>> verif/tb_matrix_row_operation_engine.sv
// Self-checking testbench for matrix_row_operation_engine: directed table, then random
// requests per size setting, each result checked against its typed table entry or an
// in-bench row-operation predictor. Depends on mroe_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb_matrix_row_operation_engine;
    import mroe_pkg::*;

    localparam int NROW = 16;
    localparam int NCOL = 16;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        mroe_req_t req;
        bit        typed;
        mroe_rsp_t rsp;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    mroe_req_t request;
    logic      done;
    mroe_rsp_t result;
    logic      cfg_wr_en;
    logic      cfg_index;
    logic [4:0] cfg_data;

    // Predictor state
    logic [31:0] elem [NROW][NCOL];
    bit          written [NROW][NCOL];
    int          rows_in_use;
    int          cols_in_use;

    mroe_rsp_t   pending_rsp_q[$];
    int          fail_count;
    int          stall_cycles;
    dir_row_t    dir_rows[$];

    matrix_row_operation_engine u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Q16.16 product, nearest with ties toward plus infinity
    function automatic longint q_mul(longint a, longint b);
        longint p;
        p = a * b + 32768;
        if (p >= 0)
            return p / 65536;
        return -((-p + 65535) / 65536);
    endfunction

    // Q16.16 quotient, nearest with ties away from zero
    function automatic longint q_div(longint a, longint b);
        longint n;
        longint un;
        longint ub;
        longint q;
        n = a * 65536;
        un = (n < 0) ? -n : n;
        ub = (b < 0) ? -b : b;
        q = (un + ub / 2) / ub;
        return ((n < 0) != (b < 0)) ? -q : q;
    endfunction

    function automatic logic [31:0] clamp32(longint v, ref bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic bit row_ready(int r);
        for (int i = 0; i < cols_in_use; i++)
            if (!written[r][i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Apply one request to the predictor matrix and return the expected result
    function automatic mroe_rsp_t apply_row_op(mroe_req_t rq);
        mroe_rsp_t rsp;
        bit        sat;
        bit        needs_b;
        longint    x;
        longint    e;
        logic [31:0] t;
        rsp = '0;
        sat = 1'b0;
        x = longint'(rq.value);
        needs_b = (rq.op == OP_SWAP) || (rq.op == OP_ADD);
        if (rq.op == OP_WRITE || rq.op == OP_READ) begin
            if (rq.row_a >= rows_in_use || rq.col >= cols_in_use)
                rsp.status = STAT_RANGE;
            else if (rq.op == OP_WRITE) begin
                elem[rq.row_a][rq.col] = rq.value;
                written[rq.row_a][rq.col] = 1'b1;
            end else
                rsp.read_data = elem[rq.row_a][rq.col];
        end else if (rq.op inside {OP_SWAP, OP_MUL, OP_DIV, OP_ADD}) begin
            if (rq.row_a >= rows_in_use || (needs_b && rq.row_b >= rows_in_use))
                rsp.status = STAT_RANGE;
            else if (rq.op == OP_DIV && x == 0)
                rsp.status = STAT_DIVZ;
            else begin
                for (int i = 0; i < cols_in_use; i++) begin
                    e = longint'($signed(elem[rq.row_a][i]));
                    case (rq.op)
                        OP_SWAP: begin
                            t = elem[rq.row_a][i];
                            elem[rq.row_a][i] = elem[rq.row_b][i];
                            elem[rq.row_b][i] = t;
                        end
                        OP_MUL: elem[rq.row_a][i] = clamp32(q_mul(e, x), sat);
                        OP_DIV: elem[rq.row_a][i] = clamp32(q_div(e, x), sat);
                        default: elem[rq.row_a][i] = clamp32(
                            e + q_mul(x, longint'($signed(elem[rq.row_b][i]))), sat);
                    endcase
                end
                if (sat)
                    rsp.status = STAT_SAT;
            end
        end
        return rsp;
    endfunction

    // Check each result against the oldest expectation
    always @(posedge clk) begin
        mroe_rsp_t want;
        if (rst_n && done) begin
            if (pending_rsp_q.size() == 0) begin
                $error("result with no request outstanding: read_data %h status %0d",
                       result.read_data, result.status);
                fail_count++;
            end else begin
                want = pending_rsp_q.pop_front();
                if (result.read_data !== want.read_data) begin
                    $error("read_data expected %h actual %h", want.read_data, result.read_data);
                    fail_count++;
                end
                if (result.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, result.status);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: case ($urandom_range(0, 3))
                   0: return 32'h7fffffff;
                   1: return 32'h80000000;
                   2: return 32'h0;
                   default: return 32'hffffffff;
               endcase
            default: return $urandom_range(0, 32'h80000) - 32'h40000;
        endcase
    endfunction

    function automatic logic [3:0] pick_row();
        if (rows_in_use > 0 && $urandom_range(0, 99) < 88)
            return 4'($urandom_range(0, (rows_in_use > NROW ? NROW : rows_in_use) - 1));
        return 4'($urandom_range(0, 15));
    endfunction

    // Random request; ops that would touch unwritten entries become writes
    function automatic mroe_req_t pick_request();
        mroe_req_t rq;
        int        r;
        int        k;
        k = $urandom_range(0, 99);
        if (k < 22)      rq.op = OP_WRITE;
        else if (k < 38) rq.op = OP_READ;
        else if (k < 52) rq.op = OP_SWAP;
        else if (k < 68) rq.op = OP_MUL;
        else if (k < 80) rq.op = OP_DIV;
        else if (k < 96) rq.op = OP_ADD;
        else             rq.op = 3'($urandom_range(6, 7));
        rq.row_a = pick_row();
        rq.row_b = pick_row();
        if (cols_in_use > 0 && $urandom_range(0, 9) != 0)
            rq.col = 4'($urandom_range(0, cols_in_use - 1));
        else
            rq.col = 4'($urandom_range(0, 15));
        rq.value = pick_value();
        if (rq.op == OP_READ && rq.row_a < rows_in_use && rq.col < cols_in_use
            && !written[rq.row_a][rq.col])
            rq.op = OP_WRITE;
        if (rq.op inside {OP_SWAP, OP_MUL, OP_DIV, OP_ADD} && rq.row_a < rows_in_use
            && (!(rq.op inside {OP_SWAP, OP_ADD}) || rq.row_b < rows_in_use)) begin
            r = -1;
            if (!row_ready(rq.row_a))
                r = rq.row_a;
            else if (rq.op inside {OP_SWAP, OP_ADD} && !row_ready(rq.row_b))
                r = rq.row_b;
            if (r >= 0) begin
                rq.op = OP_WRITE;
                rq.row_a = 4'(r);
                for (int i = cols_in_use - 1; i >= 0; i--)
                    if (!written[r][i])
                        rq.col = 4'(i);
                rq.value = $urandom();
            end
        end
        return rq;
    endfunction

    // Send one request, record its expectation, then idle for a random gap
    task automatic send_request(input mroe_req_t rq, input bit typed, input mroe_rsp_t typed_rsp);
        mroe_rsp_t p;
        int        gap;
        int        k;
        start <= 1'b1;
        request <= rq;
        do @(posedge clk); while (busy);
        p = apply_row_op(rq);
        pending_rsp_q.push_back(typed ? typed_rsp : p);
        k = $urandom_range(0, 99);
        if (k < 55)      gap = 0;
        else if (k < 90) gap = $urandom_range(1, 3);
        else             gap = $urandom_range(5, 40);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drain outstanding results, then write both size registers
    task automatic set_size(input logic [4:0] rows, input logic [4:0] cols);
        start <= 1'b0;
        @(posedge clk);
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ROW_COUNT;
        cfg_data <= rows;
        @(posedge clk);
        cfg_index <= CFG_COL_COUNT;
        cfg_data <= cols;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        rows_in_use = (rows > NROW) ? NROW : rows;
        cols_in_use = (cols > NCOL) ? NCOL : cols;
    endtask

    function automatic void add_row(logic [2:0] op, int ra, int rb, int c, logic [31:0] v,
                                    bit typed, logic [31:0] d, logic [1:0] st);
        dir_row_t row;
        row.req.op = op;
        row.req.row_a = 4'(ra);
        row.req.row_b = 4'(rb);
        row.req.col = 4'(c);
        row.req.value = v;
        row.typed = typed;
        row.rsp.read_data = d;
        row.rsp.status = st;
        dir_rows.push_back(row);
    endfunction

    initial begin
        logic [4:0] size_rows [7];
        logic [4:0] size_cols [7];
        int         phase_len [7];
        size_rows = '{16, 1, 0, 31, 3, 16, 8};
        size_cols = '{16, 1, 7, 31, 16, 2, 5};
        phase_len = '{60, 40, 20, 220, 90, 150, 120};
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_ROW_COUNT;
        cfg_data = '0;
        fail_count = 0;
        stall_cycles = 0;
        rows_in_use = NROW;
        cols_in_use = NCOL;
        foreach (written[r, c])
            written[r][c] = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table on a 2x2 matrix
        add_row(OP_WRITE, 0, 0, 0, 32'h7fffffff, 1, 0, STAT_OK);
        add_row(OP_WRITE, 0, 0, 1, 32'h80000000, 1, 0, STAT_OK);
        add_row(OP_WRITE, 1, 0, 0, 32'h00010000, 1, 0, STAT_OK);
        add_row(OP_WRITE, 1, 0, 1, 32'hfffe8000, 1, 0, STAT_OK);
        add_row(OP_READ,  0, 0, 0, 0, 1, 32'h7fffffff, STAT_OK);
        add_row(OP_READ,  0, 0, 1, 0, 1, 32'h80000000, STAT_OK);
        add_row(OP_READ,  2, 0, 0, 0, 1, 0, STAT_RANGE);
        add_row(OP_READ,  0, 0, 15, 0, 1, 0, STAT_RANGE);
        add_row(OP_WRITE, 15, 0, 15, 32'h12345678, 1, 0, STAT_RANGE);
        add_row(OP_SWAP,  0, 1, 0, 0, 0, 0, STAT_OK);
        add_row(OP_SWAP,  0, 2, 0, 0, 1, 0, STAT_RANGE);
        add_row(OP_SWAP,  1, 1, 0, 0, 0, 0, STAT_OK);
        add_row(OP_MUL,   1, 0, 0, 32'h00020000, 1, 0, STAT_SAT);
        add_row(OP_DIV,   0, 0, 0, 32'h0, 1, 0, STAT_DIVZ);
        add_row(OP_DIV,   5, 0, 0, 32'h0, 1, 0, STAT_RANGE);
        add_row(OP_DIV,   0, 0, 0, 32'h00030000, 0, 0, STAT_OK);
        add_row(OP_DIV,   0, 0, 0, 32'hffff0000, 0, 0, STAT_OK);
        add_row(OP_ADD,   0, 1, 0, 32'h00008000, 0, 0, STAT_OK);
        add_row(OP_ADD,   1, 1, 0, 32'h00010000, 0, 0, STAT_OK);
        add_row(OP_ADD,   0, 9, 0, 32'h00010000, 1, 0, STAT_RANGE);
        add_row(3'd6,     15, 15, 15, 32'hffffffff, 1, 0, STAT_OK);
        add_row(3'd7,     0, 0, 0, 32'h0, 1, 0, STAT_OK);
        add_row(OP_READ,  1, 0, 1, 0, 0, 0, STAT_OK);
        add_row(OP_MUL,   0, 0, 0, 32'h80000000, 0, 0, STAT_OK);
        add_row(OP_READ,  0, 0, 0, 0, 0, 0, STAT_OK);

        set_size(2, 2);
        foreach (dir_rows[i])
            send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

        // Random requests over a range of sizes
        for (int ph = 0; ph < 7; ph++) begin
            set_size(size_rows[ph], size_cols[ph]);
            repeat (phase_len[ph])
                send_request(pick_request(), 1'b0, '0);
        end

        // Let the last results drain
        start <= 1'b0;
        @(posedge clk);
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_rsp_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
